// ===== hw/rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

    typedef logic [31:0] word_t;

    // Commands from the sequencer to the round unit.
    typedef struct packed {
        logic init;   // return the chaining hash to the initial value
        logic load;   // copy the chaining hash into the working variables
        logic step;   // run one compression round
        logic accum;  // add the working variables into the chaining hash
    } round_ctl_t;

    // Commands from the sequencer to the message schedule.
    typedef struct packed {
        logic       put_byte;    // shift one message byte into the block
        logic [7:0] byte_val;
        logic       shift_word;  // advance the schedule window by one word
    } sched_ctl_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t v;
        unique case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== hw/rtl/sha256_sched.sv =====
`timescale 1ns / 1ps

// Holds the 64-byte block and turns it into the rolling 16-word schedule window.
module sha256_sched
    import sha256_pkg::*;
(
    input  logic       clk,
    input  sched_ctl_t ctl,
    output word_t      w_t
);

    logic [511:0] msg_reg;
    logic [511:0] msg_next;
    word_t        w_new;

    assign w_t   = msg_reg[511:480];
    assign w_new = msg_reg[511:480] + small_sigma0(msg_reg[479:448])
                 + msg_reg[223:192] + small_sigma1(msg_reg[63:32]);

    always_comb
    begin
        msg_next = msg_reg;
        if (ctl.put_byte)
        begin
            msg_next = {msg_reg[503:0], ctl.byte_val};
        end
        else if (ctl.shift_word)
        begin
            msg_next = {msg_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

endmodule

// ===== hw/rtl/sha256_round.sv =====
`timescale 1ns / 1ps

// One compression round per step, plus the chaining hash and its update.
module sha256_round
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  round_ctl_t ctl,
    input  logic [5:0] round_idx,
    input  word_t      w_t,
    input  logic [2:0] word_idx,
    output word_t      hash_word
);

    word_t hash_reg [8];
    word_t hash_next [8];
    word_t var_reg [8];
    word_t var_next [8];
    word_t t1;
    word_t t2;

    assign t1 = var_reg[7] + big_sigma1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + round_k(round_idx) + w_t;
    assign t2 = big_sigma0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    assign hash_word = hash_reg[word_idx];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
            var_next[i]  = var_reg[i];
        end
        if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = init_hash(3'(i));
            end
        end
        else if (ctl.accum)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + var_reg[i];
            end
        end
        if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_next[i] = hash_reg[i];
            end
        end
        else if (ctl.step)
        begin
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
                var_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
                var_reg[i]  <= var_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/sha256_stream_hasher_top.sv =====
// Channel | Dir | tdata              | tuser            | tlast
// s_*     | in  | [7:0] data_byte    | [0] has_byte     | end_of_message
// m_*     | out | [31:0] digest_word | [2:0] word_index | last_word
//
// A request is taken in a single handshake; one that fills the 64-byte block also runs the
// 64 rounds on the single round unit and one hash update before the next request is taken.
// An end request shifts in padding and length one byte per cycle, pausing to compress a full
// block (up to 72 bytes over one or two blocks); the digest follows the last compression.
// No request is taken while the block works or emits; a stalled sink holds the word.
// Reset (asynchronous, active low) loads the initial hash; no clearing pass is needed.
`timescale 1ns / 1ps

module sha256_stream_hasher_top
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_COMP  = 3'd1;  // running the 64 rounds
    localparam logic [2:0] ST_FINAL = 3'd2;  // adding the rounds into the hash
    localparam logic [2:0] ST_PAD   = 3'd3;  // shifting in 0x80 and zero padding
    localparam logic [2:0] ST_LEN   = 3'd4;  // shifting in the 64-bit bit length
    localparam logic [2:0] ST_OUT   = 3'd5;  // emitting the digest words

    logic [2:0]  state_reg,  state_next;
    logic [5:0]  pos_reg,    pos_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [5:0]  round_reg,  round_next;
    logic [2:0]  widx_reg,   widx_next;
    logic        pend_reg,   pend_next;   // padding still to do after this block
    logic        lastblk_reg, lastblk_next; // block under way carries the length
    logic        first_reg,  first_next;  // next padding byte is the 0x80 marker

    round_ctl_t  rctl;
    sched_ctl_t  sctl;
    word_t       w_t;
    word_t       hash_word;
    logic        in_fire;
    logic        out_fire;
    logic [7:0]  len_byte;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    assign m_tdata = hash_word;
    assign m_tuser = widx_reg;
    assign m_tlast = (widx_reg == LAST_INDEX);

    // Length bytes go out most significant first while the position runs 56..63.
    assign len_byte = 8'(bitlen_reg >> {~pos_reg[2:0], 3'b000});

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        bitlen_next  = bitlen_reg;
        round_next   = round_reg;
        widx_next    = widx_reg;
        pend_next    = pend_reg;
        lastblk_next = lastblk_reg;
        first_next   = first_reg;
        rctl         = '0;
        sctl         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser)
                    begin
                        sctl.put_byte = 1'b1;
                        sctl.byte_val = s_tdata;
                        pos_next      = pos_reg + 6'd1;
                        bitlen_next   = bitlen_reg + 64'd8;
                    end
                    first_next = 1'b1;
                    if (s_tuser && (pos_reg == LAST_POS))
                    begin
                        rctl.load  = 1'b1;
                        round_next = '0;
                        pend_next  = s_tlast;
                        state_next = ST_COMP;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP:
            begin
                rctl.step       = 1'b1;
                sctl.shift_word = 1'b1;
                round_next      = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                rctl.accum = 1'b1;
                if (lastblk_reg)
                begin
                    widx_next  = '0;
                    state_next = ST_OUT;
                end
                else if (pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                sctl.put_byte = 1'b1;
                sctl.byte_val = first_reg ? PAD_BYTE : 8'h00;
                first_next    = 1'b0;
                pos_next      = pos_reg + 6'd1;
                if (pos_reg == LAST_POS)
                begin
                    // Marker landed too late for the length: one more block.
                    rctl.load  = 1'b1;
                    round_next = '0;
                    pend_next  = 1'b1;
                    state_next = ST_COMP;
                end
                else if (pos_reg == LENGTH_POS - 6'd1)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                sctl.put_byte = 1'b1;
                sctl.byte_val = len_byte;
                pos_next      = pos_reg + 6'd1;
                if (pos_reg == LAST_POS)
                begin
                    rctl.load    = 1'b1;
                    round_next   = '0;
                    lastblk_next = 1'b1;
                    state_next   = ST_COMP;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == LAST_INDEX)
                    begin
                        rctl.init    = 1'b1;
                        pos_next     = '0;
                        bitlen_next  = '0;
                        pend_next    = 1'b0;
                        lastblk_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            bitlen_reg  <= '0;
            round_reg   <= '0;
            widx_reg    <= '0;
            pend_reg    <= 1'b0;
            lastblk_reg <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            bitlen_reg  <= bitlen_next;
            round_reg   <= round_next;
            widx_reg    <= widx_next;
            pend_reg    <= pend_next;
            lastblk_reg <= lastblk_next;
            first_reg   <= first_next;
        end
    end

    sha256_sched u_sched (
        .clk (clk),
        .ctl (sctl),
        .w_t (w_t)
    );

    sha256_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rctl),
        .round_idx (round_reg),
        .w_t       (w_t),
        .word_idx  (widx_reg),
        .hash_word (hash_word)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides open at once");

    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser && (pos_reg == LAST_POS)) |=> (state_reg == ST_COMP))
        else $error("full block did not start compression");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMP) && (round_reg == LAST_ROUND)) |=> (state_reg == ST_FINAL))
        else $error("compression did not end after the last round");

    a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN) |-> (pos_reg >= LENGTH_POS))
        else $error("length written before its place in the block");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> ((state_reg == ST_IDLE) && (bitlen_reg == 64'd0)
                                   && (pos_reg == 6'd0)))
        else $error("state not cleared after the digest");
`endif

endmodule

// ===== tb/sv/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] digest_word
    input  logic [2:0]  m_tuser,   // [2:0] word_index
    input  logic        m_tlast,
    output int          pending_words,
    output int          fail_count
);

    typedef struct packed {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_word_t;

    localparam word_t HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    word_t        chain_h [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [63:0]  msg_bits;
    digest_word_t digest_q [$];
    int           fail_total;

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One full compression of the 64 bytes in blk into the chaining hash.
    function automatic void absorb_block();
        word_t w [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        word_t s0;
        word_t s1;
        int    i;
        for (i = 0; i < 16; i++)
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
        for (i = 16; i < 64; i++)
        begin
            s0 = ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3);
            s1 = ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10);
            w[i] = w[i - 16] + s0 + w[i - 7] + s1;
        end
        for (i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    // Applies one accepted request and queues the digest that an end request yields.
    function automatic void take_request(input logic [7:0] b, input logic has,
                                         input logic eom);
        digest_word_t dw;
        int           p;
        int           i;
        if (has)
        begin
            blk[fill] = b;
            msg_bits = msg_bits + 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                absorb_block();
        end
        if (eom)
        begin
            p = fill;
            blk[p] = PAD_BYTE;
            for (i = p + 1; i < 64; i++)
                blk[i] = 8'h00;
            // No room left for the length: it goes into a second, otherwise empty block.
            if (p >= LENGTH_POS)
            begin
                absorb_block();
                for (i = 0; i < 64; i++)
                    blk[i] = 8'h00;
            end
            for (i = 0; i < 8; i++)
                blk[LENGTH_POS + i] = msg_bits[63 - 8 * i -: 8];
            absorb_block();
            for (i = 0; i < 8; i++)
            begin
                dw.word = chain_h[i];
                dw.idx  = 3'(i);
                dw.last = (3'(i) == LAST_INDEX);
                digest_q = {digest_q, dw};
            end
            for (i = 0; i < 8; i++)
                chain_h[i] = HASH_IV[i];
            fill = 6'd0;
            msg_bits = 64'd0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_h[i] = HASH_IV[i];
            fill = 6'd0;
            msg_bits = 64'd0;
            digest_q.delete();
            fail_total = 0;
            pending_words <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_request(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest word %h arrived with nothing outstanding", m_tdata);
                    fail_total++;
                end
                else
                begin
                    due = digest_q.pop_front();
                    if (m_tdata !== due.word)
                    begin
                        $error("digest_word: expected %h, got %h", due.word, m_tdata);
                        fail_total++;
                    end
                    if (m_tuser !== due.idx)
                    begin
                        $error("word_index: expected %0d, got %0d", due.idx, m_tuser);
                        fail_total++;
                    end
                    if (m_tlast !== due.last)
                    begin
                        $error("last_word: expected %0d, got %0d", due.last, m_tlast);
                        fail_total++;
                    end
                end
            end
            pending_words <= digest_q.size();
            fail_count <= fail_total;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // The hasher never accepts a request while it compresses or emits, so a
    // long quiet spell on both channels is normal; this bound is several times
    // the worst of a two-block finish, the long sink hold-off and random stalls.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles for which the sink refuses every digest word during the pressure test.
    localparam int HOLD_CYCLES    = 300;
    // Settling time after the last digest word, well beyond the two-block finish.
    localparam int DRAIN_CYCLES   = 300;
    // Chance, in per cent, of an empty request in front of each message byte.
    localparam int NOISE_PCT      = 10;
    // Request budget of each of the four random phases; the message under way
    // when the budget runs out is still finished.
    localparam int PHASE_REQUESTS = 26;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] has_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [2:0]  m_tuser;   // [2:0] word_index
    logic        m_tlast;

    int pending_words;
    int fail_count;

    // Idling controls, set by the stimulus and read by the sender task and the sink.
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    // The stimulus bumps hold_asked; the sink answers with one long hold-off each time.
    int hold_asked = 0;
    int hold_done = 0;

    int requests_sent = 0;
    int messages_sent = 0;
    int two_block_msgs = 0;
    int quiet_cycles = 0;

    sha256_stream_hasher_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The checker sits beside the block, mirrors every accepted request into
    // its own hash model and compares each digest word as it leaves.
    sha256_digest_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sink side. It stalls at random at the rate the current phase asks for,
    // and on request refuses every word for a long stretch so that the block
    // backs up and stops taking requests.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done = hold_done + 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // The watchdog measures the quiet time since the last request or digest word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: watchdog expired with %0d digest words outstanding",
                     pending_words);
            $display("tb_top: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request, after a random number of idle cycles, and holds it
    // until the block takes it. The valid line is left high on return so that
    // back-to-back requests need no idle cycle between them.
    task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= has;
        s_tlast <= eom;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        if (eom)
            messages_sent++;
    endtask

    // A message of random bytes with empty requests sprinkled in. It ends
    // either on its last byte or with a separate end request that carries no byte.
    task automatic send_message(input int len, input bit byte_on_end);
        int k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < NOISE_PCT)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, byte_on_end && (k == len - 1));
        end
        if (len == 0 || !byte_on_end)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        if (len % 64 >= 56)
            two_block_msgs++;
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int sel;
        int len;

        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The empty message straight after reset; the byte lines are all ones
        // but must be ignored.
        send_item(8'hff, 1'b0, 1'b1);
        // An empty request changes nothing, then "abc" ending on its last byte.
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // Byte extremes, closed by an end request without a byte.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // A single byte equal to the padding marker, then the empty message again.
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // Back-pressure: the sink holds off while three short messages keep
        // coming, so the block must stall its input behind the first digest.
        hold_asked = hold_asked + 1;
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b1);
        send_item(8'hed, 1'b0, 1'b1);
        send_item(8'h7e, 1'b1, 1'b1);

        // Random messages in four idling phases. Lengths cluster around the
        // point where padding spills into a second block and around two blocks;
        // most are short to keep the run brief.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin send_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                sel = $urandom_range(99);
                if (sel < 55)
                    len = $urandom_range(12);
                else if (sel < 90)
                    len = $urandom_range(65, 54);
                else
                    len = $urandom_range(130, 118);
                send_message(len, 1'($urandom_range(1)));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d requests in %0d messages, %0d digest words checked",
                 requests_sent, messages_sent, messages_sent * 8);
        $display("tb_top: %0d random messages needed a second padding block",
                 two_block_msgs);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
